// ----- src/lfu_cache_lookup_insert_macros.svh -----
// ----------------------------------------------------------------------------
// LFU cache assertion macros
// Shared helpers for concurrent checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_LOOKUP_INSERT_MACROS_SVH
`define LFU_CACHE_LOOKUP_INSERT_MACROS_SVH

// same-cycle implication
`define LFU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfu cache assertion failed");

// next-cycle implication
`define LFU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfu cache assertion failed");

`endif

// ----- src/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants for the LFU cache and its entry memory.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int KEY_W          = 32;
  localparam int VAL_W          = 32;
  localparam int CFG_W          = 5;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // address width for a store of the given depth, at least one bit
  function automatic int addr_bits(input int depth);
    addr_bits = (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

// ----- src/lfu_ram.sv -----
// ----------------------------------------------------------------------------
// lfu_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/lfu_cache_lookup_insert.sv -----
// ----------------------------------------------------------------------------
// lfu_cache_lookup_insert
// Key-value cache with least-frequently-used replacement, LRU tie-break.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to issue a get or put. Busy stays high
// after start is taken while the block issues the first read, reads each
// entry memory word to match the key and pick the eviction victim, then
// runs the update state. The result appears on the out_ ports for exactly
// one cycle with out_valid high, in the first cycle with busy low; it
// cannot be held off, so capture it then. A new item may start in that
// same cycle. Recency ranks and valid bits live in flops; key, value and
// use count live in the entry RAM. Reset clears all entries at once.
// Write capacity through the cfg_ port only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_lookup_insert #(
  parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             in_opcode,
  input  wire logic signed [lfu_pkg::KEY_W-1:0] in_lookup_key,
  input  wire logic signed [lfu_pkg::VAL_W-1:0] in_write_value,
  output logic                                  out_valid,
  output logic                                  out_hit,
  output logic signed [lfu_pkg::VAL_W-1:0]      out_read_value,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lfu_pkg::CFG_W-1:0]        cfg_data
);

  import lfu_pkg::*;
  `include "lfu_cache_lookup_insert_macros.svh"

  localparam int IW  = addr_bits(CAPACITY);
  localparam int OW  = $clog2(CAPACITY + 1);
  localparam int WW  = KEY_W + VAL_W + COUNT_BITS;
  localparam logic [IW-1:0]         LAST_IDX  = IW'(CAPACITY - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] cap_r;
  logic [OW-1:0]    occ_r, occ_nxt;
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [IW-1:0]    rank_r [CAPACITY];
  logic [IW-1:0]    rank_nxt [CAPACITY];

  // latched item
  logic             op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] wval_r;

  // scan pipeline
  logic          issue_r;
  logic [IW-1:0] addr_r;
  logic          rd_vld_r;
  logic [IW-1:0] rd_idx_r;

  // scan trackers
  logic                  hit_r;
  logic [IW-1:0]         mi_r;
  logic [VAL_W-1:0]      mval_r;
  logic [COUNT_BITS-1:0] mcnt_r;
  logic [IW-1:0]         mrank_r;
  logic                  vfound_r;
  logic [IW-1:0]         vi_r;
  logic [COUNT_BITS-1:0] vcnt_r;
  logic [IW-1:0]         vrank_r;
  logic                  ffound_r;
  logic [IW-1:0]         fi_r;

  logic                  out_valid_r, out_hit_r;
  logic [VAL_W-1:0]      out_val_r;

  // RAM
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata, ram_rdata;

  lfu_ram #(
    .WIDTH (WW),
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue_r),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // entry word fields
  logic [KEY_W-1:0]      rd_key;
  logic [VAL_W-1:0]      rd_val;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  rd_ent_vld;
  logic [IW-1:0]         rd_rank;

  assign rd_key     = ram_rdata[WW-1 -: KEY_W];
  assign rd_val     = ram_rdata[COUNT_BITS +: VAL_W];
  assign rd_cnt     = ram_rdata[COUNT_BITS-1:0];
  assign rd_ent_vld = valid_r[rd_idx_r];
  assign rd_rank    = rank_r[rd_idx_r];

  logic better_victim;
  assign better_victim = !vfound_r || (rd_cnt < vcnt_r) ||
                         ((rd_cnt == vcnt_r) && (rd_rank > vrank_r));

  // update decisions
  logic [OW-1:0] capc;
  logic          do_touch, do_ins, do_evict;
  logic [IW-1:0] slot;

  assign capc     = (32'(cap_r) > CAPACITY) ? OW'(CAPACITY) : OW'(cap_r);
  assign do_touch = hit_r && ((op_r == OP_GET) || (capc != '0));
  assign do_ins   = !hit_r && (op_r == OP_PUT) && (capc != '0);
  assign do_evict = do_ins && (occ_r >= capc) && vfound_r;
  assign slot     = (do_evict && (!ffound_r || (vi_r < fi_r))) ? vi_r : fi_r;

  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int j = 0; j < CAPACITY; j++) begin
      rank_nxt[j] = rank_r[j];
    end
    if (state_r == ST_UPD) begin
      if (do_touch) begin
        for (int j = 0; j < CAPACITY; j++) begin
          if (valid_r[j] && (rank_r[j] < mrank_r)) begin
            rank_nxt[j] = rank_r[j] + 1'b1;
          end
        end
        rank_nxt[mi_r] = '0;
      end else if (do_ins) begin
        for (int j = 0; j < CAPACITY; j++) begin
          if (valid_r[j]) begin
            if (do_evict && (rank_r[j] > vrank_r)) begin
              rank_nxt[j] = rank_r[j];
            end else begin
              rank_nxt[j] = rank_r[j] + 1'b1;
            end
          end
        end
        if (do_evict) begin
          valid_nxt[vi_r] = 1'b0;
        end
        valid_nxt[slot] = 1'b1;
        rank_nxt[slot]  = '0;
        if (!do_evict) begin
          occ_nxt = occ_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    ram_we    = (state_r == ST_UPD) && (do_touch || do_ins);
    ram_waddr = do_touch ? mi_r : slot;
    if (do_touch) begin
      ram_wdata = {key_r, (op_r == OP_GET) ? mval_r : wval_r,
                   (mcnt_r == COUNT_MAX) ? mcnt_r : mcnt_r + 1'b1};
    end else begin
      ram_wdata = {key_r, wval_r, COUNT_BITS'(1)};
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SCAN;
      ST_SCAN: if (rd_vld_r && (rd_idx_r == LAST_IDX)) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      valid_r     <= '0;
      issue_r     <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= (state_r == ST_UPD);
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if ((state_r == ST_IDLE) && start) begin
        issue_r  <= 1'b1;
        rd_vld_r <= 1'b0;
      end else begin
        // advance the read address until the last entry is issued
        rd_vld_r <= issue_r;
        if (issue_r && (addr_r == LAST_IDX)) begin
          issue_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < CAPACITY; j++) begin
      rank_r[j] <= rank_nxt[j];
    end
    if ((state_r == ST_IDLE) && start) begin
      op_r     <= in_opcode;
      key_r    <= in_lookup_key;
      wval_r   <= in_write_value;
      addr_r   <= '0;
      hit_r    <= 1'b0;
      vfound_r <= 1'b0;
      ffound_r <= 1'b0;
    end else begin
      if (issue_r) begin
        rd_idx_r <= addr_r;
        if (addr_r != LAST_IDX) begin
          addr_r <= addr_r + 1'b1;
        end
      end
      if (rd_vld_r && (state_r == ST_SCAN)) begin
        if (rd_ent_vld) begin
          if (!hit_r && (rd_key == key_r)) begin
            hit_r   <= 1'b1;
            mi_r    <= rd_idx_r;
            mval_r  <= rd_val;
            mcnt_r  <= rd_cnt;
            mrank_r <= rd_rank;
          end
          if (better_victim) begin
            vfound_r <= 1'b1;
            vi_r     <= rd_idx_r;
            vcnt_r   <= rd_cnt;
            vrank_r  <= rd_rank;
          end
        end else if (!ffound_r) begin
          ffound_r <= 1'b1;
          fi_r     <= rd_idx_r;
        end
      end
    end
    if (state_r == ST_UPD) begin
      out_hit_r <= hit_r;
      if (op_r == OP_GET) begin
        out_val_r <= hit_r ? mval_r : '1;
      end else begin
        out_val_r <= '0;
      end
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_val_r;

  `LFU_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid_r, state_r == ST_IDLE)
  `LFU_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `LFU_ASSERT_NXT(a_upd_result, clk, rst_n, state_r == ST_UPD, out_valid_r)
  `LFU_ASSERT_IMP(a_occ_match, clk, rst_n, 1'b1, $countones(valid_r) == 32'(occ_r))

endmodule

`default_nettype wire

// ----- dv/lfu_cache_lookup_insert_tb.sv -----
// ----------------------------------------------------------------------------
// lfu_cache_lookup_insert_tb
// Drives gets and puts through the LFU cache under several capacity
// settings, predicts each result with a behavioral cache model and checks
// every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfu_cache_lookup_insert_tb;
  import lfu_pkg::*;

  localparam int NUM_ENTRIES = CAPACITY_DEF;
  localparam int USE_BITS    = COUNT_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 2 * NUM_ENTRIES + 8;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
  } lookup_result_t;

  class cache_scoreboard;
    logic                   valid_q [NUM_ENTRIES];
    logic [KEY_W-1:0]       key_q   [NUM_ENTRIES];
    logic [VAL_W-1:0]       value_q [NUM_ENTRIES];
    logic [USE_BITS-1:0]    uses_q  [NUM_ENTRIES];
    int unsigned            rank_q  [NUM_ENTRIES];
    int unsigned            occupancy;
    logic [CFG_W-1:0]       capacity;
    lookup_result_t         pending_results [$];
    int unsigned            mismatches;
    int unsigned            checked;
    int unsigned            hits_seen;
    int unsigned            evictions;

    function new();
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        valid_q[i] = 1'b0;
        key_q[i] = '0;
        value_q[i] = '0;
        uses_q[i] = '0;
        rank_q[i] = 0;
      end
      occupancy = 0;
      capacity = CAP_RESET;
      mismatches = 0;
      checked = 0;
      hits_seen = 0;
      evictions = 0;
    endfunction

    function void set_capacity(logic [CFG_W-1:0] cap);
      capacity = cap;
    endfunction

    function void touch(int idx);
      for (int j = 0; j < NUM_ENTRIES; j++)
        if (valid_q[j] && rank_q[j] < rank_q[idx]) rank_q[j]++;
      rank_q[idx] = 0;
      if (uses_q[idx] != '1) uses_q[idx]++;
    endfunction

    function void evict_victim();
      int victim;
      victim = -1;
      for (int j = 0; j < NUM_ENTRIES; j++) begin
        if (!valid_q[j]) continue;
        if (victim < 0 || uses_q[j] < uses_q[victim] ||
            (uses_q[j] == uses_q[victim] && rank_q[j] > rank_q[victim]))
          victim = j;
      end
      if (victim < 0) return;
      valid_q[victim] = 1'b0;
      evictions++;
      for (int j = 0; j < NUM_ENTRIES; j++)
        if (valid_q[j] && rank_q[j] > rank_q[victim]) rank_q[j]--;
      if (occupancy > 0) occupancy--;
    endfunction

    function void insert_entry(logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
      int slot;
      slot = -1;
      for (int j = 0; j < NUM_ENTRIES; j++)
        if (!valid_q[j] && slot < 0) slot = j;
      if (slot < 0) return;
      for (int j = 0; j < NUM_ENTRIES; j++)
        if (valid_q[j]) rank_q[j]++;
      valid_q[slot] = 1'b1;
      key_q[slot] = key;
      value_q[slot] = val;
      uses_q[slot] = 1;
      rank_q[slot] = 0;
      occupancy++;
    endfunction

    // predict the result of one accepted item and update the cache image
    function void note_item(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
      int idx;
      int unsigned cap;
      lookup_result_t res;
      idx = -1;
      cap = (capacity > NUM_ENTRIES) ? NUM_ENTRIES : capacity;
      for (int j = 0; j < NUM_ENTRIES; j++)
        if (idx < 0 && valid_q[j] && key_q[j] == key) idx = j;
      res.hit = (idx >= 0);
      res.value = '0;
      if (op == OP_GET) begin
        if (idx >= 0) begin
          res.value = value_q[idx];
          touch(idx);
        end else begin
          res.value = '1;
        end
      end else if (cap != 0) begin
        if (idx >= 0) begin
          value_q[idx] = val;
          touch(idx);
        end else begin
          if (occupancy >= cap) evict_victim();
          insert_entry(key, val);
        end
      end
      pending_results.push_back(res);
    endfunction

    function void check_result(logic hit, logic [VAL_W-1:0] value);
      lookup_result_t exp_res;
      checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hit=%0b value=%08h", hit, value);
        return;
      end
      exp_res = pending_results.pop_front();
      if (exp_res.hit) hits_seen++;
      if (hit !== exp_res.hit || value !== exp_res.value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected hit=%0b value=%08h, got hit=%0b value=%08h",
                   checked, exp_res.hit, exp_res.value, hit, value);
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic                    in_opcode;
  logic signed [KEY_W-1:0] in_lookup_key;
  logic signed [VAL_W-1:0] in_write_value;
  logic                    out_valid;
  logic                    out_hit;
  logic signed [VAL_W-1:0] out_read_value;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_W-1:0]        cfg_data;

  cache_scoreboard lookups;
  int unsigned     cycle_count = 0;
  bit              quiet_phase;
  logic [KEY_W-1:0] key_pool [8];

  lfu_cache_lookup_insert i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) lookups.check_result(out_hit, out_read_value);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("lfu_cache_lookup_insert: mismatch");
      $finish;
    end
  end

  task automatic idle_gap();
    if (!quiet_phase && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  // issue one item and hold start until the block takes it
  task automatic send_item(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    start <= 1'b1;
    in_opcode <= op;
    in_lookup_key <= key;
    in_write_value <= val;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    lookups.note_item(op, key, val);
    @(negedge clk);
    start <= 1'b0;
    // hold start low before the next item; the block is busy anyway
    @(negedge clk);
    idle_gap();
  endtask

  task automatic wait_drained();
    while (lookups.pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] cap);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    lookups.set_capacity(cap);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_items(int count);
    logic [KEY_W-1:0] key;
    for (int n = 0; n < count; n++) begin
      // mostly reuse a small key pool so hits, updates and evictions happen
      if ($urandom_range(0, 9) < 8)
        key = key_pool[$urandom_range(0, 7)] + KEY_W'($urandom_range(0, 2));
      else key = $urandom();
      send_item(1'($urandom_range(0, 1)), key, $urandom());
    end
  endtask

  initial begin
    lookups = new();
    quiet_phase = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_GET;
    in_lookup_key = '0;
    in_write_value = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    for (int k = 0; k < 8; k++) key_pool[k] = $urandom();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, hits, misses, updates, eviction ties
    send_item(OP_GET, 32'h8000_0000, 32'h0);
    send_item(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_PUT, 32'h0, 32'h0);
    send_item(OP_GET, 32'h8000_0000, 32'h1234_5678);
    send_item(OP_GET, 32'h7FFF_FFFF, 32'h0);
    send_item(OP_PUT, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
    send_item(OP_GET, 32'hFFFF_FFFF, 32'h0);
    send_item(OP_GET, 32'h0, 32'h0);
    write_capacity(5'd2);
    send_item(OP_PUT, 32'h11, 32'h1);
    send_item(OP_PUT, 32'h22, 32'h2);
    send_item(OP_GET, 32'h0, 32'h0);
    send_item(OP_GET, 32'h22, 32'h0);
    write_capacity(5'd0);
    send_item(OP_PUT, 32'h33, 32'h3);
    send_item(OP_PUT, 32'h22, 32'h9);
    send_item(OP_GET, 32'h22, 32'h0);
    write_capacity(5'd31);
    send_item(OP_PUT, 32'h44, 32'h4);
    send_item(OP_GET, 32'h44, 32'h0);

    // random phases under several capacities
    write_capacity(5'd16);
    random_items(400);
    write_capacity(5'd1);
    random_items(200);
    write_capacity(5'd4);
    random_items(300);
    write_capacity(5'd0);
    random_items(100);
    write_capacity(5'd7);
    random_items(300);
    wait_drained();
    write_capacity(5'd31);
    random_items(300);
    quiet_phase = 1'b1;
    write_capacity(5'd16);
    random_items(200);

    wait_drained();
    $display("covered %0d results, %0d hits, %0d evictions, capacities 0 to 31",
             lookups.checked, lookups.hits_seen, lookups.evictions);
    if (lookups.mismatches == 0 && lookups.pending_results.size() == 0)
      $display("lfu_cache_lookup_insert: match");
    else
      $display("lfu_cache_lookup_insert: mismatch");
    $finish;
  end

endmodule
